[rtl/core/srpc_pkg.sv]
// srpc_pkg: shared constants and types for the sensor reply packet checker
// no dependencies; used by the top level, input stage, parser and output stage
`timescale 1ns / 1ps
`default_nettype none

package srpc_pkg;

   localparam int unsigned PosWidth = 4;

   localparam logic [PosWidth-1:0] PosHdr0     = 4'd0;
   localparam logic [PosWidth-1:0] PosHdr1     = 4'd1;
   localparam logic [PosWidth-1:0] PosHdr2     = 4'd2;
   localparam logic [PosWidth-1:0] PosType     = 4'd3;
   localparam logic [PosWidth-1:0] PosAddress  = 4'd4;
   localparam logic [PosWidth-1:0] PosValue0   = 4'd5;
   localparam logic [PosWidth-1:0] PosValue1   = 4'd6;
   localparam logic [PosWidth-1:0] PosValue2   = 4'd7;
   localparam logic [PosWidth-1:0] PosValue3   = 4'd8;
   localparam logic [PosWidth-1:0] PosSumHigh  = 4'd9;
   localparam logic [PosWidth-1:0] PosSumLow   = 4'd10;
   localparam logic [PosWidth-1:0] PosComplete = 4'd11;

   localparam logic [7:0] Hdr0Byte = 8'h73;   // 's'
   localparam logic [7:0] Hdr1Byte = 8'h6E;   // 'n'
   localparam logic [7:0] Hdr2Byte = 8'h70;   // 'p'
   localparam logic [7:0] TypeByte = 8'h80;

   // one received byte as held in the input register
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_item_type;

   // one finished packet verdict
   typedef struct packed {
      logic        packet_ok;
      logic [7:0]  register_address;
      logic [31:0] value_bits;
   } rsp_item_type;

endpackage

`default_nettype wire

[rtl/core/sensor_reply_packet_checker_top.sv]
// sensor_reply_packet_checker_top: top level of the sensor reply packet checker
// depends on srpc_pkg, srpc_in_stage, srpc_parser and srpc_out_stage
//
// usage
//  - request channel: one received uart byte per transfer (req_rx_byte) with
//    req_frame_start high on the first byte of a new receive window
//  - the block checks the 11-byte reply: header 's','n','p', type byte 0x80
//    and a 16-bit sum of bytes 0 to 8 against the big-endian checksum in
//    bytes 9 and 10
//  - response channel: one transfer per complete packet, on its eleventh
//    byte, with the pass flag, the address byte and the 32-bit value
//  - bytes after the eleventh are swallowed until the next start flag; a
//    start flag mid-packet drops the partial packet without a response
//  - the eleventh byte passes through the input register, then its result through the output register, to rsp_valid
//  - throughput: one byte per cycle, bar a completing byte held by the output,
//    set by the single input register and single pass through the parser logic
//  - a finished result waiting in the output register does not block bytes
//    that cause no result; only a second completing byte waits behind it
//  - reset (synchronous, active high) empties both registers and makes the
//    block expect byte 0 of a packet, even without a start flag
//  - while rsp_valid and rsp_stall are both high the response payload holds steady
`timescale 1ns / 1ps
`default_nettype none

module sensor_reply_packet_checker_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_frame_start,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_packet_ok,
   output logic [7:0]       rsp_register_address,
   output logic [31:0]      rsp_value_bits
);

   srpc_pkg::req_item_type req_item;
   srpc_pkg::req_item_type item;
   srpc_pkg::rsp_item_type result;
   srpc_pkg::rsp_item_type rsp_item;
   logic item_valid;
   logic done;
   logic out_free;
   logic advance;
   logic out_load;

   assign req_item.rx_byte     = req_rx_byte;
   assign req_item.frame_start = req_frame_start;

   // a byte moves on unless it completes a packet while the output is full and stalled
   assign advance  = item_valid & (~done | out_free);
   assign out_load = advance & done;

   srpc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // packet state and checks, updated once per byte that moves on
   srpc_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .done    (done),
      .result  (result)
   );

   srpc_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .result    (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_packet_ok        = rsp_item.packet_ok;
   assign rsp_register_address = rsp_item.register_address;
   assign rsp_value_bits       = rsp_item.value_bits;

endmodule

`default_nettype wire

[rtl/core/srpc_in_stage.sv]
// srpc_in_stage: input register holding one received byte and its start flag
// depends on srpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module srpc_in_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire srpc_pkg::req_item_type req_item,
   input  wire logic                  advance,
   output logic                       item_valid,
   output srpc_pkg::req_item_type     item
);

   logic                   valid_ff;
   logic                   valid_in;
   srpc_pkg::req_item_type item_ff;
   logic                   load;

   // the register takes a new byte when empty or when its byte moves on
   assign req_stall = valid_ff & ~advance;
   assign load      = req_valid & ~req_stall;
   assign valid_in  = load | (valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

[rtl/core/srpc_parser.sv]
// srpc_parser: packet position, header checks, checksum and field capture
// depends on srpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module srpc_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire srpc_pkg::req_item_type item,
   output logic                        done,
   output srpc_pkg::rsp_item_type      result
);

   logic [srpc_pkg::PosWidth-1:0] pos_ff, pos_in, pos_base;
   logic [15:0] sum_ff, sum_in, sum_base;
   logic        match_ff, match_in, match_base;
   logic [7:0]  addr_ff, addr_in, addr_base;
   logic [31:0] value_ff, value_in, value_base;
   logic [7:0]  b;

   assign b = item.rx_byte;

   // start flag drops any partial packet
   always_comb begin
      if (item.frame_start) begin
         pos_base   = srpc_pkg::PosHdr0;
         sum_base   = '0;
         match_base = 1'b1;
         addr_base  = '0;
         value_base = '0;
      end else begin
         pos_base   = pos_ff;
         sum_base   = sum_ff;
         match_base = match_ff;
         addr_base  = addr_ff;
         value_base = value_ff;
      end
   end

   always_comb begin
      pos_in   = pos_base;
      sum_in   = sum_base;
      match_in = match_base;
      addr_in  = addr_base;
      value_in = value_base;
      done     = 1'b0;
      if (pos_base < srpc_pkg::PosComplete) begin
         pos_in = pos_base + 1'b1;
         done   = (pos_base == srpc_pkg::PosSumLow);
         if (pos_base < srpc_pkg::PosSumHigh) begin
            sum_in = sum_base + {8'h00, b};
         end
         case (pos_base)
            srpc_pkg::PosHdr0:    match_in = match_base & (b == srpc_pkg::Hdr0Byte);
            srpc_pkg::PosHdr1:    match_in = match_base & (b == srpc_pkg::Hdr1Byte);
            srpc_pkg::PosHdr2:    match_in = match_base & (b == srpc_pkg::Hdr2Byte);
            srpc_pkg::PosType:    match_in = match_base & (b == srpc_pkg::TypeByte);
            srpc_pkg::PosAddress: addr_in  = b;
            srpc_pkg::PosValue0,
            srpc_pkg::PosValue1,
            srpc_pkg::PosValue2,
            srpc_pkg::PosValue3:  value_in = {value_base[23:0], b};
            srpc_pkg::PosSumHigh: match_in = match_base & (b == sum_base[15:8]);
            default:              match_in = match_base & (b == sum_base[7:0]);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= srpc_pkg::PosHdr0;
         sum_ff   <= '0;
         match_ff <= 1'b1;
         addr_ff  <= '0;
         value_ff <= '0;
      end else if (advance) begin
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         match_ff <= match_in;
         addr_ff  <= addr_in;
         value_ff <= value_in;
      end
   end

   assign result.packet_ok        = match_in;
   assign result.register_address = addr_in;
   assign result.value_bits       = value_in;

endmodule

`default_nettype wire

[rtl/core/srpc_out_stage.sv]
// srpc_out_stage: result register towards the response channel
// depends on srpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module srpc_out_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire srpc_pkg::rsp_item_type result,
   output logic                        free,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output srpc_pkg::rsp_item_type      rsp_item
);

   logic                   valid_ff;
   logic                   valid_in;
   srpc_pkg::rsp_item_type item_ff;

   assign free     = ~valid_ff | ~rsp_stall;
   assign valid_in = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

`default_nettype wire

[rtl/core/srpc_checker.sv]
// srpc_checker: port-level checks for the sensor reply packet checker
// depends on sensor_reply_packet_checker_top, attached by bind
`timescale 1ns / 1ps
`default_nettype none

module srpc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_packet_ok,
   input wire logic [7:0]  rsp_register_address,
   input wire logic [31:0] rsp_value_bits
);

   // input only waits behind a response that is itself held up
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a blocked response");

   a_reset_no_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_reset_no_stall: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("request stalled right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_packet_ok) && $stable(rsp_register_address)
          && $stable(rsp_value_bits)))
      else $error("stalled response changed");

endmodule

bind sensor_reply_packet_checker_top srpc_checker u_srpc_checker (
   .clock                (clock),
   .reset                (reset),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_packet_ok        (rsp_packet_ok),
   .rsp_register_address (rsp_register_address),
   .rsp_value_bits       (rsp_value_bits)
);

`default_nettype wire

[sim/sensor_reply_packet_checker_top_tb.sv]
// sensor_reply_packet_checker_top_tb: self-checking bench for the sensor reply packet checker
// depends on srpc_pkg and sensor_reply_packet_checker_top; a small verdict tracker predicts
// each packet verdict from the accepted bytes and checks every response transfer against it
`timescale 1ns / 1ps

module sensor_reply_packet_checker_top_tb;

   localparam int unsigned ReplyLen   = 11;
   localparam int unsigned StallLimit = 2000;  // cycles with no transfer before giving up
   localparam int unsigned HoldCycles = 300;   // long receiver hold-off
   localparam int unsigned PhaseBytes = 160;

   typedef logic [7:0] reply_bytes_type [ReplyLen];

   typedef enum int {
      StimGood,
      StimCorrupt,
      StimTruncated,
      StimUnflagged,
      StimNoise
   } stim_kind_type;

   // predicts the verdict of each reply from the bytes that were taken in
   class packet_verdict_tracker_type;
      logic [srpc_pkg::PosWidth-1:0] position;
      logic [15:0]                   byte_sum;
      logic                          all_match;
      logic [7:0]                    address_hold;
      logic [31:0]                   value_hold;
      srpc_pkg::rsp_item_type        expected_verdicts[$];
      int unsigned                   bytes_parsed;
      int unsigned                   mismatches;

      function new();
         restart();
         bytes_parsed = 0;
         mismatches   = 0;
      endfunction

      function void restart();
         position     = srpc_pkg::PosHdr0;
         byte_sum     = '0;
         all_match    = 1'b1;
         address_hold = '0;
         value_hold   = '0;
      endfunction

      function void note_byte(logic [7:0] rx, logic frame_start);
         srpc_pkg::rsp_item_type verdict;
         if (frame_start)
            restart();
         if (position >= srpc_pkg::PosComplete)
            return;
         if (position < srpc_pkg::PosSumHigh)
            byte_sum = byte_sum + {8'h00, rx};
         case (position)
            srpc_pkg::PosHdr0:    all_match = all_match && (rx == srpc_pkg::Hdr0Byte);
            srpc_pkg::PosHdr1:    all_match = all_match && (rx == srpc_pkg::Hdr1Byte);
            srpc_pkg::PosHdr2:    all_match = all_match && (rx == srpc_pkg::Hdr2Byte);
            srpc_pkg::PosType:    all_match = all_match && (rx == srpc_pkg::TypeByte);
            srpc_pkg::PosAddress: address_hold = rx;
            srpc_pkg::PosValue0,
            srpc_pkg::PosValue1,
            srpc_pkg::PosValue2,
            srpc_pkg::PosValue3:
               value_hold = {value_hold[23:0], rx};
            srpc_pkg::PosSumHigh: all_match = all_match && (rx == byte_sum[15:8]);
            default:              all_match = all_match && (rx == byte_sum[7:0]);
         endcase
         position = position + 1'b1;
         bytes_parsed++;
         if (position == srpc_pkg::PosComplete) begin
            verdict.packet_ok        = all_match;
            verdict.register_address = address_hold;
            verdict.value_bits       = value_hold;
            expected_verdicts.push_back(verdict);
         end
      endfunction

      function void check_verdict(logic ok, logic [7:0] address, logic [31:0] value);
         srpc_pkg::rsp_item_type want;
         if (expected_verdicts.size() == 0) begin
            $error("response transfer with no packet outstanding: ok %0d address %0h value %0h",
                   ok, address, value);
            mismatches++;
            return;
         end
         want = expected_verdicts.pop_front();
         if (ok !== want.packet_ok) begin
            $error("packet_ok: expected %0d actual %0d", want.packet_ok, ok);
            mismatches++;
         end
         if (address !== want.register_address) begin
            $error("register_address: expected %0h actual %0h", want.register_address, address);
            mismatches++;
         end
         if (value !== want.value_bits) begin
            $error("value_bits: expected %0h actual %0h", want.value_bits, value);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte     = 8'h00;
   logic        req_frame_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic        rsp_packet_ok;
   logic [7:0]  rsp_register_address;
   logic [31:0] rsp_value_bits;

   packet_verdict_tracker_type tracker;

   int unsigned sender_gap_pct     = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned holdoff_requests   = 0;  // bumped by the stimulus only
   int unsigned holdoffs_served    = 0;  // bumped by the receiver only
   int unsigned hold_left          = 0;
   int unsigned quiet_cycles       = 0;

   always #1 clock = ~clock;

   sensor_reply_packet_checker_top DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_rx_byte          (req_rx_byte),
      .req_frame_start      (req_frame_start),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_packet_ok        (rsp_packet_ok),
      .rsp_register_address (rsp_register_address),
      .rsp_value_bits       (rsp_value_bits)
   );

   // receiver: random stalls, or a long hold-off when the stimulus asks for one
   always @(posedge clock) begin
      if (holdoffs_served != holdoff_requests) begin
         holdoffs_served <= holdoff_requests;
         hold_left       <= HoldCycles;
         rsp_stall       <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // monitor and watchdog: values read here are the ones the block saw at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            tracker.note_byte(req_rx_byte, req_frame_start);
         if (rsp_valid && !rsp_stall)
            tracker.check_verdict(rsp_packet_ok, rsp_register_address, rsp_value_bits);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= StallLimit) begin
            $display("Verification failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // mostly random bytes, with the two extremes well represented
   function automatic logic [7:0] pick_byte();
      int unsigned roll;
      roll = $urandom_range(7);
      if (roll == 0)
         return 8'h00;
      if (roll == 1)
         return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   // a well-formed reply with its checksum over bytes 0 to 8
   function automatic reply_bytes_type build_reply(logic [7:0] address, logic [31:0] value);
      reply_bytes_type pkt;
      logic [15:0]     sum;
      pkt[0] = srpc_pkg::Hdr0Byte;
      pkt[1] = srpc_pkg::Hdr1Byte;
      pkt[2] = srpc_pkg::Hdr2Byte;
      pkt[3] = srpc_pkg::TypeByte;
      pkt[4] = address;
      pkt[5] = value[31:24];
      pkt[6] = value[23:16];
      pkt[7] = value[15:8];
      pkt[8] = value[7:0];
      sum = '0;
      for (int i = 0; i < 9; i++)
         sum = sum + {8'h00, pkt[i]};
      pkt[9]  = sum[15:8];
      pkt[10] = sum[7:0];
      return pkt;
   endfunction

   // offer one byte and hold it until the block takes it
   task automatic offer_byte(logic [7:0] rx, logic frame_start);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_rx_byte     <= rx;
      req_frame_start <= frame_start;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic send_reply(reply_bytes_type pkt, logic flagged, int unsigned count);
      for (int i = 0; i < count; i++)
         offer_byte(pkt[i], (i == 0) && flagged);
   endtask

   task automatic send_random_reply();
      reply_bytes_type pkt;
      stim_kind_type   kind;
      int unsigned     roll;
      int unsigned     idx;
      roll = $urandom_range(99);
      pkt  = build_reply(pick_byte(), {pick_byte(), pick_byte(), pick_byte(), pick_byte()});
      if (roll < 60)
         kind = StimGood;
      else if (roll < 78)
         kind = StimCorrupt;
      else if (roll < 88)
         kind = StimTruncated;
      else if (roll < 93)
         kind = StimUnflagged;
      else
         kind = StimNoise;
      case (kind)
         StimGood:
            send_reply(pkt, 1'b1, ReplyLen);
         StimCorrupt: begin
            // one byte anywhere in the reply changed to a different value
            idx      = $urandom_range(ReplyLen - 1);
            pkt[idx] = pkt[idx] ^ 8'($urandom_range(255, 1));
            send_reply(pkt, 1'b1, ReplyLen);
         end
         StimTruncated:
            send_reply(pkt, 1'b1, $urandom_range(ReplyLen - 1, 1));
         StimUnflagged:
            send_reply(pkt, 1'b0, ReplyLen);
         default:
            repeat ($urandom_range(5, 1))
               offer_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      endcase
      // trailing bytes after a reply; swallowed when the reply was complete
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(2, 1))
            offer_byte(pick_byte(), 1'b0);
   endtask

   initial begin
      reply_bytes_type pkt;
      int unsigned     target;
      tracker = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first reply straight after reset with no start flag, all-ones payload
      send_reply(build_reply(8'hFF, 32'hFFFF_FFFF), 1'b0, ReplyLen);
      // byte after the eleventh is ignored
      offer_byte(8'hA5, 1'b0);
      // partial reply cut short by a new start flag
      send_reply(build_reply(8'h12, 32'h3456_789A), 1'b1, 2);
      // all-zero payload with a wrong type byte
      pkt    = build_reply(8'h00, 32'h0000_0000);
      pkt[3] = 8'h7F;
      send_reply(pkt, 1'b1, ReplyLen);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
            1:       begin sender_gap_pct = 66; receiver_stall_pct = 0;  end
            2:       begin sender_gap_pct = 0;  receiver_stall_pct = 66; end
            default: begin sender_gap_pct = 34; receiver_stall_pct = 34; end
         endcase
         target = tracker.bytes_parsed + PhaseBytes;
         if (phase == 0) begin
            repeat (3) send_random_reply();
            // receiver holds off while good replies keep coming, filling the block
            holdoff_requests++;
            repeat (4)
               send_reply(build_reply(pick_byte(), {pick_byte(), pick_byte(), pick_byte(),
                          pick_byte()}), 1'b1, ReplyLen);
         end
         while (tracker.bytes_parsed < target)
            send_random_reply();
      end

      req_valid <= 1'b0;
      while (tracker.expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected_verdicts.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
